### hdl/hboc_pkg.sv
package hboc_pkg;

  localparam int MAX_BUCKETS = 1024;
  localparam int COUNT_WIDTH = 16;

  localparam int ADDR_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int KEY_W   = 31;
  localparam int IDX_W   = 10;
  localparam int DIV_W   = 11;
  localparam int OCC_W   = 16;
  localparam int STEP_W  = $clog2(KEY_W);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [ADDR_W-1:0]      addr_t;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_READ   = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic   rd_en;
    addr_t  rd_addr;
    logic   wr_en;
    addr_t  wr_addr;
    count_t wr_data;
  } mem_req_t;

  // Zero divides as one; anything above the table size is clamped to it.
  function automatic logic [DIV_W-1:0] clamp_divisor(input logic [DIV_W-1:0] cfg);
    logic [DIV_W-1:0] d;
    d = cfg;
    if (cfg == '0) begin
      d = DIV_W'(1);
    end else if (32'(cfg) > MAX_BUCKETS) begin
      d = DIV_W'(MAX_BUCKETS);
    end
    return d;
  endfunction

  function automatic count_t sat_inc(input count_t c);
    count_t r;
    r = c;
    if (c != '1) begin
      r = c + count_t'(1);
    end
    return r;
  endfunction

  function automatic logic [OCC_W-1:0] sat_occ(input count_t c);
    logic [OCC_W-1:0] r;
    r = OCC_W'(c);
    if (32'(c) > 32'h0000_FFFF) begin
      r = '1;
    end
    return r;
  endfunction

endpackage

### hdl/hboc_mod_div.sv
// Restoring remainder unit: one key bit per cycle, MSB first.
module hboc_mod_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [hboc_pkg::KEY_W-1:0] dividend,
  input  logic [hboc_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [hboc_pkg::DIV_W-1:0] remainder
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [hboc_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic [hboc_pkg::KEY_W-1:0]  dvd_r, dvd_nxt;
  logic [hboc_pkg::DIV_W-1:0]  rem_r, rem_nxt;
  logic [hboc_pkg::DIV_W-1:0]  dsr_r, dsr_nxt;
  logic [hboc_pkg::DIV_W:0]    trial;

  assign trial = {rem_r, dvd_r[hboc_pkg::KEY_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = hboc_pkg::STEP_W'(hboc_pkg::KEY_W - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // trial < 2*divisor, so one subtract restores it
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = hboc_pkg::DIV_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = hboc_pkg::DIV_W'(trial);
      end
      dvd_nxt = {dvd_r[hboc_pkg::KEY_W-2:0], 1'b0};
      cnt_nxt = cnt_r - hboc_pkg::STEP_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

### hdl/hboc_count_store.sv
// Counter memory: one write and one registered read per cycle.
module hboc_count_store (
  input  logic               clk,
  input  hboc_pkg::mem_req_t req,
  output hboc_pkg::count_t   rd_data
);

  hboc_pkg::count_t mem [hboc_pkg::MAX_BUCKETS];
  hboc_pkg::count_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    // read data holds until the next read
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/hash_bucket_occupancy_counter_unit.sv
// Per-bucket occupancy counter for division-method hashing. An insert
// transaction (func 0) adds one, saturating, to the counter of bucket
// key mod bucket_count and gives no result; a read transaction (func 1)
// returns the count of bucket_index and clears it. After reset the block
// zeroes all MAX_BUCKETS (1024) counters in the memory with in_stall
// high; cfg writes are taken during that pass. Items are handled one at
// a time: an insert runs through the accept, the bit-serial remainder
// unit (one key bit at a time), the memory read and the write-back; a
// read is accepted with the memory read issued and written back once no
// previous result is still stalled in the output register. A pending
// result does not block acceptance of the next transaction. bucket_count
// of zero divides as one, and values above MAX_BUCKETS are clamped;
// changing it leaves all counters untouched.
module hash_bucket_occupancy_counter_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [hboc_pkg::DIV_W-1:0]   cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [hboc_pkg::KEY_W-1:0]   in_key,
  input  logic [hboc_pkg::IDX_W-1:0]   in_bucket_index,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hboc_pkg::IDX_W-1:0]   out_read_bucket,
  output logic [hboc_pkg::OCC_W-1:0]   out_occupancy
);

  hboc_pkg::state_t           state_r, state_nxt;
  logic [hboc_pkg::DIV_W-1:0] bucket_count_r;
  hboc_pkg::addr_t            clr_addr_r, clr_addr_nxt;

  // item context held across the multi-cycle operation
  hboc_pkg::func_t            op_r;
  logic [hboc_pkg::IDX_W-1:0] idx_r;
  logic                       in_range_r;
  hboc_pkg::addr_t            addr_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [hboc_pkg::IDX_W-1:0] out_bucket_r;
  logic [hboc_pkg::OCC_W-1:0] out_occ_r;

  logic                       accept;
  logic                       idx_in_range;
  logic                       clr_last;
  logic                       out_free;
  logic                       update_go;
  logic                       load_out;
  logic                       div_start;
  logic                       div_done;
  logic [hboc_pkg::DIV_W-1:0] div_rem;
  hboc_pkg::mem_req_t         mem_req;
  hboc_pkg::count_t           mem_rd_data;

  assign accept       = in_valid && !in_stall;
  assign idx_in_range = (32'(in_bucket_index) < hboc_pkg::MAX_BUCKETS);
  assign clr_last     = (clr_addr_r == hboc_pkg::ADDR_W'(hboc_pkg::MAX_BUCKETS - 1));
  assign out_free     = !out_valid_r || !out_stall;
  // an insert never waits on the output; a read needs a free result slot
  assign update_go    = (op_r == hboc_pkg::FUNC_INSERT) || out_free;

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hboc_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = hboc_pkg::ST_IDLE;
        end
      end
      hboc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_func == hboc_pkg::FUNC_INSERT) begin
            state_nxt = hboc_pkg::ST_DIV;
          end else begin
            state_nxt = hboc_pkg::ST_UPDATE;
          end
        end
      end
      hboc_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = hboc_pkg::ST_UPDATE;
        end
      end
      hboc_pkg::ST_UPDATE: begin
        if (update_go) begin
          state_nxt = hboc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hboc_pkg::ST_CLEAR;
    endcase
  end

  // ---- outputs of the sequencer ----
  always_comb begin
    in_stall        = 1'b1;
    div_start       = 1'b0;
    load_out        = 1'b0;
    clr_addr_nxt    = clr_addr_r;
    mem_req         = '0;
    case (state_r)
      hboc_pkg::ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_addr_r;
        mem_req.wr_data = '0;
        clr_addr_nxt    = clr_addr_r + hboc_pkg::ADDR_W'(1);
      end
      hboc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          if (in_func == hboc_pkg::FUNC_INSERT) begin
            div_start = 1'b1;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = hboc_pkg::ADDR_W'(in_bucket_index);
          end
        end
      end
      hboc_pkg::ST_DIV: begin
        if (div_done) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = hboc_pkg::ADDR_W'(div_rem);
        end
      end
      hboc_pkg::ST_UPDATE: begin
        // read data is valid here and holds while a read result waits
        if (update_go) begin
          mem_req.wr_addr = addr_r;
          if (op_r == hboc_pkg::FUNC_INSERT) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = hboc_pkg::sat_inc(mem_rd_data);
          end else begin
            load_out        = 1'b1;
            mem_req.wr_en   = in_range_r;
            mem_req.wr_data = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= hboc_pkg::ST_CLEAR;
      clr_addr_r     <= '0;
      bucket_count_r <= hboc_pkg::DIV_W'(1);
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        bucket_count_r <= cfg_wdata;
      end
    end
    if (accept) begin
      op_r       <= hboc_pkg::func_t'(in_func);
      idx_r      <= in_bucket_index;
      in_range_r <= idx_in_range;
      addr_r     <= hboc_pkg::ADDR_W'(in_bucket_index);
    end else if (state_r == hboc_pkg::ST_DIV && div_done) begin
      addr_r <= hboc_pkg::ADDR_W'(div_rem);
    end
    if (load_out) begin
      out_bucket_r <= idx_r;
      // a bucket beyond the table reports zero
      out_occ_r    <= in_range_r ? hboc_pkg::sat_occ(mem_rd_data) : '0;
    end
  end

  hboc_mod_div u_mod_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_key),
    .divisor   (hboc_pkg::clamp_divisor(bucket_count_r)),
    .done      (div_done),
    .remainder (div_rem)
  );

  hboc_count_store u_count_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  assign out_valid       = out_valid_r;
  assign out_read_bucket = out_bucket_r;
  assign out_occupancy   = out_occ_r;

endmodule
